FILE: design/delimiter_stream_framer_assert.svh
// Assertion macros for the delimiter stream framer.
// Included by the top level; no other dependencies.
`ifndef DELIMITER_STREAM_FRAMER_ASSERT_SVH
`define DELIMITER_STREAM_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define DSF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsf assertion failed");
`define DSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsf assertion failed");
`else
`define DSF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define DSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/dsf_pkg.sv
// Shared types and constants of the delimiter stream framer.
// No dependencies.
package dsf_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int LIMIT_REG_W = 24;
  localparam int LEN_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 3'd4;

  localparam logic [63:0]            DELIM_RST = 64'd10;
  localparam logic [LEN_W-1:0]       LEN_RST   = 4'd1;
  localparam logic [LIMIT_REG_W-1:0] LIMIT_RST = 24'd65535;

  typedef struct packed {
    logic [63:0]            delimiter_bytes;
    logic [LEN_W-1:0]       delimiter_length;
    logic                   include_delim;
    logic                   limit_enable;
    logic [LIMIT_REG_W-1:0] frame_limit;
  } dsf_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       frame_error;
  } dsf_result_t;

  typedef struct packed {
    logic fire;
    logic err;
  } dsf_status_t;

endpackage

FILE: design/dsf_stream_if.sv
// Stream channel interfaces of the delimiter stream framer.
// Input channel carries one raw byte, result channel one framer word.
interface dsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface dsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       frame_end;
  logic       frame_error;
  modport source(output valid, output out_byte, output byte_valid,
                 output frame_end, output frame_error, input ready);
  modport sink(input valid, input out_byte, input byte_valid,
               input frame_end, input frame_error, output ready);
endinterface

FILE: design/delimiter_stream_framer.sv
// Top level of the delimiter stream framer.
// Depends on dsf_pkg, dsf_stream_if, dsf_cfg_regs, dsf_in_stage, dsf_framer_core.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      data_byte[7:0]
//  out_ch   out  valid/ready      out_byte[7:0] byte_valid frame_end frame_error
//  cfg_*    in   cfg_we (no wait) cfg_index[2:0] cfg_data[63:0]
//
// One byte word per cycle sustained while out_ch is not stalled; input passes the input
// register, then the result register after one window compare and count update.
// Synchronous active-low reset clears the window, counter, error flag and both stages.
// One input word is held while a result waits; a stalled result stalls input after that.
`include "delimiter_stream_framer_assert.svh"

module delimiter_stream_framer
  import dsf_pkg::*;
#(
  parameter int DELIM_MAX   = 8,
  parameter int LIMIT_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dsf_in_if.sink                in_ch,
  dsf_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dsf_cfg_t    cfg;
  dsf_result_t result;
  dsf_status_t status;
  logic        held_valid;
  logic [7:0]  held_byte;
  logic        core_valid;

  dsf_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  dsf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.data_byte),
    .in_ready   (in_ch.ready),
    .fire       (status.fire),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  dsf_framer_core #(
    .DELIM_MAX   (DELIM_MAX),
    .LIMIT_WIDTH (LIMIT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (held_valid),
    .in_byte   (held_byte),
    .out_ready (out_ch.ready),
    .out_valid (core_valid),
    .result    (result),
    .status    (status)
  );

  assign out_ch.valid       = core_valid;
  assign out_ch.out_byte    = result.out_byte;
  assign out_ch.byte_valid  = result.byte_valid;
  assign out_ch.frame_end   = result.frame_end;
  assign out_ch.frame_error = result.frame_error;

  `DSF_ASSERT_NEXT(a_accept_held, clk, rst_n, in_ch.valid && in_ch.ready, held_valid)
  `DSF_ASSERT_NEXT(a_held_kept, clk, rst_n, held_valid && !status.fire, held_valid)
  `DSF_ASSERT_NEXT(a_err_silent, clk, rst_n, status.err && status.fire, !out_ch.valid)
  `DSF_ASSERT_SAME(a_err_sticky, clk, rst_n, $past(status.err) && $past(rst_n), status.err)

endmodule

FILE: design/dsf_cfg_regs.sv
// Configuration register bank of the delimiter stream framer.
// Depends on dsf_pkg.
module dsf_cfg_regs
  import dsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output dsf_cfg_t              cfg
);

  dsf_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        CFG_DELIM_BYTES:  cfg_nxt.delimiter_bytes  = data[63:0];
        CFG_DELIM_LENGTH: cfg_nxt.delimiter_length = data[LEN_W-1:0];
        CFG_INCLUDE:      cfg_nxt.include_delim    = data[0];
        CFG_LIMIT_EN:     cfg_nxt.limit_enable     = data[0];
        CFG_FRAME_LIMIT:  cfg_nxt.frame_limit      = data[LIMIT_REG_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter_bytes  <= DELIM_RST;
      cfg_r.delimiter_length <= LEN_RST;
      cfg_r.include_delim    <= 1'b0;
      cfg_r.limit_enable     <= 1'b0;
      cfg_r.frame_limit      <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/dsf_in_stage.sv
// Input register stage of the delimiter stream framer.
// Holds one byte word so input can be taken while a result waits.
module dsf_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       fire,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  assign in_ready = !valid_r || fire;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

FILE: design/dsf_framer_core.sv
// Delimiter match, frame counter, limit check and result register.
// Depends on dsf_pkg.
module dsf_framer_core
  import dsf_pkg::*;
#(
  parameter int DELIM_MAX   = 8,
  parameter int LIMIT_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dsf_cfg_t    cfg,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        out_ready,
  output logic        out_valid,
  output dsf_result_t result,
  output dsf_status_t status
);

  localparam int WW = 8 * DELIM_MAX;
  localparam int CW = LIMIT_WIDTH + 1;
  localparam int XW = LIMIT_WIDTH + 2;
  localparam int LB = (LIMIT_WIDTH < LIMIT_REG_W) ? LIMIT_WIDTH : LIMIT_REG_W;
  localparam logic [LEN_W-1:0]       DM4   = LEN_W'(DELIM_MAX);
  localparam logic [CW-1:0]          CMAX  = {CW{1'b1}};
  localparam logic [LIMIT_REG_W-1:0] LMASK = {LIMIT_REG_W{1'b1}} >> (LIMIT_REG_W - LB);

  logic [WW-1:0]        win_r, win_nxt, win_new, tail;
  logic [CW-1:0]        cnt_r, cnt_nxt, n_cnt, len_c;
  logic                 err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dsf_result_t          res_r, res;
  logic                 has_res, fire, slot_free, match, err_match, err_run;
  logic [LEN_W-1:0]     len, sh;
  logic [DELIM_MAX-1:0] eq;
  logic [XW-1:0]        n_x, len_x, limit_x;

  assign slot_free = !out_valid_r || out_ready;
  assign fire      = in_valid && slot_free;

  always_comb begin
    len = cfg.delimiter_length;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (len > DM4) begin
      len = DM4;
    end
    win_new = WW'({in_byte, win_r} >> 8);
    sh      = DM4 - len;
    tail    = win_new >> {sh, 3'b000};
    for (int k = 0; k < DELIM_MAX; k++) begin
      eq[k] = (LEN_W'(k) >= len) || (tail[8*k +: 8] == cfg.delimiter_bytes[8*k +: 8]);
    end
    n_cnt     = (cnt_r == CMAX) ? cnt_r : cnt_r + CW'(1);
    len_c     = CW'(len);
    match     = (n_cnt >= len_c) && (&eq);
    n_x       = XW'(n_cnt);
    len_x     = XW'(len);
    limit_x   = XW'(cfg.frame_limit & LMASK);
    err_match = cfg.limit_enable && ((n_x - len_x) > limit_x);
    err_run   = cfg.limit_enable && ((n_x + XW'(1)) > (limit_x + len_x));

    res     = '0;
    has_res = 1'b0;
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (fire && !err_r) begin
      win_nxt = win_new;
      if (match) begin
        has_res       = 1'b1;
        res.frame_end = 1'b1;
        if (err_match) begin
          err_nxt         = 1'b1;
          res.frame_error = 1'b1;
        end else begin
          win_nxt = '0;
          cnt_nxt = '0;
          if (cfg.include_delim) begin
            res.out_byte   = in_byte;
            res.byte_valid = 1'b1;
          end
        end
      end else if (err_run) begin
        err_nxt         = 1'b1;
        has_res         = 1'b1;
        res.frame_end   = 1'b1;
        res.frame_error = 1'b1;
      end else begin
        cnt_nxt = n_cnt;
        if (cfg.include_delim) begin
          has_res        = 1'b1;
          res.out_byte   = in_byte;
          res.byte_valid = 1'b1;
        end else if (n_cnt >= len_c) begin
          has_res        = 1'b1;
          res.out_byte   = tail[7:0];
          res.byte_valid = 1'b1;
        end
      end
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = has_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      res_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign result      = res_r;
  assign status.fire = fire;
  assign status.err  = err_r;

endmodule
